### src/bsfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bsfe_pkg
// shared types and constants of the byte stuffing frame encoder
// ---------------------------------------------------------------------------
package bsfe_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CFG_IDX_W   = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOOTER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 2'd2;

  // reset values of the marker registers
  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd2;
  localparam logic [BYTE_W-1:0] FOOTER_RESET = 8'd3;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd16;

  // most beats in flight between input and output: queue, working entry and
  // output register
  localparam int unsigned MAX_PENDING = QUEUE_DEPTH + 2;

  typedef struct packed {
    logic [BYTE_W-1:0] header_byte;
    logic [BYTE_W-1:0] footer_byte;
    logic [BYTE_W-1:0] escape_byte;
  } markers_t;

  // classified item, as held in the queue
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              need_header;
    logic              need_escape;
    logic              frame_end;
  } cmd_t;

  // queue status towards the front
  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

endpackage

`default_nettype wire

### src/bsfe_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bsfe_front
// accepts payload bytes, tracks the open frame and classifies each byte
// ---------------------------------------------------------------------------
module bsfe_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [bsfe_pkg::BYTE_W-1:0] data_byte,
  input  wire logic                     frame_end,
  input  wire bsfe_pkg::markers_t       markers,
  input  wire bsfe_pkg::q_status_t      q_status,
  output logic                          push,
  output bsfe_pkg::cmd_t                push_cmd
);
  import bsfe_pkg::*;

  logic frame_open;
  logic frame_open_next;

  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_cmd.data_byte   = data_byte;
    push_cmd.need_header = !frame_open;
    push_cmd.need_escape = (data_byte == markers.escape_byte) ||
                           (data_byte == markers.footer_byte) ||
                           (data_byte == markers.header_byte);
    push_cmd.frame_end   = frame_end;
  end

  always_comb begin
    frame_open_next = frame_open;
    if (push) begin
      frame_open_next = !frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
    end else begin
      frame_open <= frame_open_next;
    end
  end

endmodule

`default_nettype wire

### src/bsfe_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bsfe_queue
// short fifo of classified items between front and back
// ---------------------------------------------------------------------------
module bsfe_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire bsfe_pkg::cmd_t      push_cmd,
  input  wire logic                pop,
  output bsfe_pkg::cmd_t           head_cmd,
  output bsfe_pkg::q_status_t      q_status
);
  import bsfe_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_status.full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_status.nonempty = (count != '0);
  assign head_cmd          = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/bsfe_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bsfe_back
// steps through header, escape, data and footer beats of each item
// ---------------------------------------------------------------------------
module bsfe_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire bsfe_pkg::markers_t          markers,
  input  wire bsfe_pkg::q_status_t         q_status,
  input  wire bsfe_pkg::cmd_t              head_cmd,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [bsfe_pkg::BYTE_W-1:0]      out_byte,
  output logic                             out_last
);
  import bsfe_pkg::*;

  typedef enum logic [4:0] {
    PH_HDR  = 5'b00001,
    PH_ESC  = 5'b00010,
    PH_DATA = 5'b00100,
    PH_FT1  = 5'b01000,
    PH_FT2  = 5'b10000
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   fin;
  } step_t;

  function automatic step_t next_step(phase_t ph, cmd_t c);
    step_t s;
    s.fin   = 1'b0;
    s.phase = PH_DATA;
    unique case (ph)
      PH_HDR:  s.phase = c.need_escape ? PH_ESC : PH_DATA;
      PH_ESC:  s.phase = PH_DATA;
      PH_DATA: begin
        s.phase = PH_FT1;
        s.fin   = !c.frame_end;
      end
      PH_FT1:  s.phase = PH_FT2;
      PH_FT2:  s.fin   = 1'b1;
      default: s.fin   = 1'b1;
    endcase
    return s;
  endfunction

  logic   busy;
  cmd_t   work_cmd;
  phase_t work_phase;

  cmd_t              src_cmd;
  phase_t            src_phase;
  step_t             nxt;
  logic              out_free;
  logic              emit;
  logic [BYTE_W-1:0] emit_byte;

  assign out_free = !out_valid || out_ready;
  assign emit     = out_free && (busy || q_status.nonempty);
  assign pop      = emit && !busy;

  always_comb begin
    src_cmd = busy ? work_cmd : head_cmd;
    if (busy) begin
      src_phase = work_phase;
    end else if (head_cmd.need_header) begin
      src_phase = PH_HDR;
    end else if (head_cmd.need_escape) begin
      src_phase = PH_ESC;
    end else begin
      src_phase = PH_DATA;
    end
    nxt = next_step(src_phase, src_cmd);
  end

  always_comb begin
    unique case (src_phase)
      PH_HDR:  emit_byte = markers.header_byte;
      PH_ESC:  emit_byte = markers.escape_byte;
      PH_DATA: emit_byte = src_cmd.data_byte;
      PH_FT1:  emit_byte = markers.footer_byte;
      PH_FT2:  emit_byte = markers.footer_byte;
      default: emit_byte = src_cmd.data_byte;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        busy      <= !nxt.fin;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (emit) begin
      work_cmd   <= src_cmd;
      work_phase <= nxt.phase;
      out_byte   <= emit_byte;
      out_last   <= nxt.fin;
    end
  end

endmodule

`default_nettype wire

### src/byte_stuffing_frame_encoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// byte_stuffing_frame_encoder_unit
// streaming byte stuffing framer with configurable header, footer and escape
// ---------------------------------------------------------------------------
// Each input beat carries one payload byte and a frame_end flag and yields
// one to five output beats: the header byte when no frame is open, an escape
// byte when the payload equals any marker, the payload byte itself, and two
// footer bytes after the last byte of a frame; out_last marks the final beat
// of each item. The output port moves one byte a cycle while out_ready
// allows it; an escaped byte inside a frame gives two beats, and the output
// register sets the sustained rate. A four-entry queue parts the input
// front from the output sequencer, so input beats keep being taken while
// the output stalls until the queue fills. The marker registers are written
// through cfg_we/cfg_index/cfg_data (index 0 header, 1 footer, 2 escape,
// 3 ignored) and should only change while idle.
// ---------------------------------------------------------------------------
module byte_stuffing_frame_encoder_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration write port
  input  wire logic                             cfg_we,
  input  wire logic [bsfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bsfe_pkg::BYTE_W-1:0]      cfg_data,
  // input beats
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [bsfe_pkg::BYTE_W-1:0]      data_byte,
  input  wire logic                             frame_end,
  // output beats
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [bsfe_pkg::BYTE_W-1:0]           out_byte,
  output logic                                  out_last
);
  import bsfe_pkg::*;

  markers_t  markers;
  q_status_t q_status;
  cmd_t      push_cmd;
  cmd_t      head_cmd;
  logic      push;
  logic      pop;

  // marker registers, unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      markers.header_byte <= HEADER_RESET;
      markers.footer_byte <= FOOTER_RESET;
      markers.escape_byte <= ESCAPE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER: markers.header_byte <= cfg_data;
        REG_FOOTER: markers.footer_byte <= cfg_data;
        REG_ESCAPE: markers.escape_byte <= cfg_data;
        default:    markers <= markers;
      endcase
    end
  end

  // front: accept and classify, owns the frame open flag
  bsfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .frame_end (frame_end),
    .markers   (markers),
    .q_status  (q_status),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // queue of classified items
  bsfe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_status (q_status)
  );

  // back: one output beat a cycle into the output register while it is free
  bsfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .markers   (markers),
    .q_status  (q_status),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire

### src/bsfe_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bsfe_checker
// port level checks of the encoder, attached by bind
// ---------------------------------------------------------------------------
module bsfe_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [bsfe_pkg::BYTE_W-1:0] out_byte,
  input wire logic                        out_last
);
  import bsfe_pkg::*;

  // items accepted whose final beat is not yet taken
  logic [3:0] pending;
  logic       in_beat;
  logic       done_beat;

  assign in_beat   = in_valid && in_ready;
  assign done_beat = out_valid && out_ready && out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 4'(in_beat) - 4'(done_beat);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output beat changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != '0)
    else $error("output beat without an accepted item");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 4'(MAX_PENDING))
    else $error("more items in flight than the design can hold");

endmodule

bind byte_stuffing_frame_encoder_unit bsfe_checker u_bsfe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .out_last  (out_last)
);

`default_nettype wire

### verif/bsfe_stream_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsfe_stream_checker
// watches the encoder ports, predicts the encoded stream and compares it
// ---------------------------------------------------------------------------
// Keeps its own marker registers and open-frame flag, follows every
// configuration write and input beat, and queues the bytes that each input
// beat should produce. Every output beat is compared with the oldest queued
// byte. The count of faults and the number of bytes still owed go to the top.
// ---------------------------------------------------------------------------
module bsfe_stream_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bsfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsfe_pkg::BYTE_W-1:0]    cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [bsfe_pkg::BYTE_W-1:0]    data_byte,
  input  logic                           frame_end,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [bsfe_pkg::BYTE_W-1:0]    out_byte,
  input  logic                           out_last,
  output int                             fault_count,
  output int                             beats_owed
);
  import bsfe_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } enc_beat_t;

  markers_t  markers;
  logic      in_frame;
  enc_beat_t owed_stream[$];
  int        faults;

  initial begin
    fault_count = 0;
    beats_owed  = 0;
  end

  // queue the one to five bytes that a payload beat turns into
  task automatic encode_payload_byte(input logic [BYTE_W-1:0] b, input logic fe);
    logic [BYTE_W-1:0] seq [5];
    int                n;
    enc_beat_t         beat;
    n = 0;
    if (!in_frame) begin
      seq[n] = markers.header_byte;
      n++;
      in_frame = 1'b1;
    end
    if (b == markers.escape_byte || b == markers.footer_byte || b == markers.header_byte) begin
      seq[n] = markers.escape_byte;
      n++;
    end
    seq[n] = b;
    n++;
    if (fe) begin
      seq[n] = markers.footer_byte;
      seq[n+1] = markers.footer_byte;
      n += 2;
      in_frame = 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      beat.value = seq[i];
      beat.last  = (i == n - 1);
      owed_stream.push_back(beat);
    end
  endtask

  always @(posedge clk) begin : watch
    enc_beat_t want;
    if (rst) begin
      markers.header_byte = HEADER_RESET;
      markers.footer_byte = FOOTER_RESET;
      markers.escape_byte = ESCAPE_RESET;
      in_frame = 1'b0;
      owed_stream.delete();
      faults = 0;
    end else begin
      // input first, so a same-edge output beat could still be matched
      if (in_valid && in_ready)
        encode_payload_byte(data_byte, frame_end);
      if (out_valid && out_ready) begin
        if (owed_stream.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("%0t: stray output beat %02h last %0b", $time, out_byte, out_last);
        end else begin
          want = owed_stream.pop_front();
          if (out_byte !== want.value || out_last !== want.last) begin
            faults++;
            if (faults <= 10)
              $display("%0t: beat error, got %02h last %0b, wanted %02h last %0b",
                       $time, out_byte, out_last, want.value, want.last);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_HEADER: markers.header_byte = cfg_data;
          REG_FOOTER: markers.footer_byte = cfg_data;
          REG_ESCAPE: markers.escape_byte = cfg_data;
          default: ;
        endcase
      end
    end
    fault_count <= faults;
    beats_owed  <= owed_stream.size();
  end

endmodule

### verif/byte_stuffing_frame_encoder_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// byte_stuffing_frame_encoder_unit_tb
// stimulus and verdict for the byte stuffing frame encoder
// ---------------------------------------------------------------------------
// Drives payload beats and marker writes into the encoder, with random gaps
// on the input and random back-pressure on the output. A directed opening
// covers byte extremes, marker collisions, one-byte frames, equal markers,
// the unused register index and a frame left open across a marker change.
// The random part sends well-formed frames of random length and content
// under a series of marker settings. The checker beside the block predicts
// and compares; this module only feeds it and reports the outcome.
// ---------------------------------------------------------------------------
module byte_stuffing_frame_encoder_unit_tb;
  import bsfe_pkg::*;

  // the one index that the encoder must ignore
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // cycles with no beat moving before the run is called hung
  localparam int STALL_LIMIT = 5000;
  // idle chance per cycle, in percent
  localparam int GAP_PCT = 15;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 25;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    data_byte = '0;
  logic                 frame_end = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [BYTE_W-1:0]    out_byte;
  logic                 out_last;

  int                   fault_count;
  int                   beats_owed;
  int                   stalled_cycles = 0;

  // no idling on either side while set
  logic                 quiet = 1'b0;
  // marker values as last written, used to bias the payload towards them
  markers_t             marker_cfg;

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  byte_stuffing_frame_encoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .frame_end (frame_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  bsfe_stream_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .frame_end   (frame_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .fault_count (fault_count),
    .beats_owed  (beats_owed)
  );

  // output back-pressure, off during the quiet stretch
  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(0, 99) >= GAP_PCT);
  end

  // hang detector: any beat moving on either channel restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      stalled_cycles <= 0;
    else
      stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one payload beat; returns at the edge where it is taken, valid left high
  // so the next call can keep it up without a glitch
  task automatic send_payload(input logic [BYTE_W-1:0] b, input logic fe);
    if (!quiet) begin
      while ($urandom_range(0, 99) < GAP_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    frame_end <= fe;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid and wait until every owed output beat has gone out
  task automatic await_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (beats_owed != 0);
  endtask

  task automatic write_marker(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_HEADER: marker_cfg.header_byte = val;
      REG_FOOTER: marker_cfg.footer_byte = val;
      REG_ESCAPE: marker_cfg.escape_byte = val;
      default: ;
    endcase
  endtask

  // full marker update, only called with the encoder drained
  task automatic load_markers(input logic [BYTE_W-1:0] h, input logic [BYTE_W-1:0] f,
                              input logic [BYTE_W-1:0] e, input logic poke_unused);
    write_marker(REG_HEADER, h);
    write_marker(REG_FOOTER, f);
    write_marker(REG_ESCAPE, e);
    if (poke_unused)
      write_marker(REG_UNUSED, BYTE_W'($urandom_range(0, 255)));
    cfg_we <= 1'b0;
  endtask

  // payload byte, hitting a marker value about three times in ten
  function automatic logic [BYTE_W-1:0] pick_payload();
    case ($urandom_range(0, 9))
      0: return marker_cfg.header_byte;
      1: return marker_cfg.footer_byte;
      2: return marker_cfg.escape_byte;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_extreme();
    return $urandom_range(0, 1) ? 8'hff : 8'h00;
  endfunction

  initial begin
    int                frame_left;
    logic [BYTE_W-1:0] h, f, e;
    marker_cfg.header_byte = HEADER_RESET;
    marker_cfg.footer_byte = FOOTER_RESET;
    marker_cfg.escape_byte = ESCAPE_RESET;
    frame_left = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset markers: byte extremes and each marker colliding inside a frame
    send_payload(8'h00, 1'b0);
    send_payload(8'hff, 1'b0);
    send_payload(HEADER_RESET, 1'b0);
    send_payload(FOOTER_RESET, 1'b0);
    send_payload(ESCAPE_RESET, 1'b1);
    // one-byte frames, escaped and plain
    send_payload(FOOTER_RESET, 1'b1);
    send_payload(8'h55, 1'b1);
    // frame left open across the marker change below
    send_payload(8'haa, 1'b0);
    await_drain();

    // new markers mid-frame, plus a write to the unused index
    load_markers(8'h00, 8'hff, 8'h7e, 1'b1);
    send_payload(8'h00, 1'b0);
    send_payload(8'hff, 1'b0);
    send_payload(8'h7e, 1'b0);
    send_payload(8'h01, 1'b1);
    send_payload(8'hff, 1'b1);
    await_drain();

    // all three markers equal: a colliding byte gets a single escape
    load_markers(8'h7e, 8'h7e, 8'h7e, 1'b0);
    send_payload(8'h7e, 1'b1);
    send_payload(8'h7d, 1'b0);
    send_payload(8'h7e, 1'b1);
    await_drain();

    // markers at the extremes
    load_markers(8'hff, 8'h00, 8'hff, 1'b1);
    send_payload(8'hff, 1'b1);
    send_payload(8'h00, 1'b1);
    await_drain();

    // random frames under a fresh marker setting per phase; frames may stay
    // open across a phase boundary
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: begin
          h = BYTE_W'($urandom_range(0, 255));
          f = BYTE_W'($urandom_range(0, 255));
          e = BYTE_W'($urandom_range(0, 255));
        end
        1: begin
          h = BYTE_W'($urandom_range(0, 255));
          f = h;
          e = h;
        end
        2: begin
          h = pick_extreme();
          f = pick_extreme();
          e = pick_extreme();
        end
        default: begin
          h = HEADER_RESET;
          f = FOOTER_RESET;
          e = ESCAPE_RESET;
        end
      endcase
      load_markers(h, f, e, $urandom_range(0, 2) == 0);
      // two phases in the middle run flat out with no idling at all
      quiet <= (p == 2 || p == 3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (frame_left == 0)
          frame_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(1, 5);
        frame_left--;
        send_payload(pick_payload(), frame_left == 0);
      end
      await_drain();
    end

    // let any stray late beats show up before the verdict
    repeat (20) @(posedge clk);
    if (fault_count == 0 && beats_owed == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
